### rtl/fifo_readers_writer_lock_top_macros.svh
// Assertion helpers for the lock arbiter. Both forms are disabled while the
// synchronous active-low reset is low and are compiled out when SYNTH is set.
`ifndef FIFO_READERS_WRITER_LOCK_TOP_MACROS_SVH
`define FIFO_READERS_WRITER_LOCK_TOP_MACROS_SVH

`ifndef SYNTH
`define FWL_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lock arbiter check failed");
`define FWL_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lock arbiter check failed");
`else
`define FWL_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define FWL_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif

`endif

### rtl/fwl_pkg.sv
`default_nettype none

package fwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int LIMIT_W     = 5;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int READERS_W   = 9;

    localparam logic [READERS_W-1:0] READERS_MAX = '1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(16);

    localparam logic [1:0] CMD_ENTER_READ  = 2'd0;
    localparam logic [1:0] CMD_LEAVE_READ  = 2'd1;
    localparam logic [1:0] CMD_ENTER_WRITE = 2'd2;
    localparam logic [1:0] CMD_LEAVE_WRITE = 2'd3;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NO_HOLDER = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] requester_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]      status;
        logic            grant_valid;
        logic [ID_W-1:0] grant_id;
        logic            grant_kind;
        logic            last;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            kind;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_q_ctl;

endpackage

`default_nettype wire

### rtl/fwl_wait_queue.sv
`default_nettype none

module fwl_wait_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  fwl_pkg::t_q_ctl  i_ctl,
    output logic [fwl_pkg::CNT_W-1:0] o_count,
    output fwl_pkg::t_entry        o_head_entry
);
    import fwl_pkg::*;

    t_entry            mem [QUEUE_DEPTH];
    t_entry            r_rdata;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  r_tail;
    logic [PTR_W-1:0]  n_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // The read address follows the next head, so the registered data belongs to
    // the current head unless a push wrote that slot as it was read. A push never
    // meets a release walk on the same cycle, so a walk always reads the head afresh.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_ctl.entry;
        end
        r_rdata <= mem[n_head];
    end

    assign o_count      = r_count;
    assign o_head_entry = r_rdata;

endmodule

`default_nettype wire

### rtl/fifo_readers_writer_lock_top.sv
// Enter words and leaves that free nobody are answered in the cycle after accept.
// A leave that frees queued readers reads the queue head on accept, then grants one
// reader per walk step and marks the last grant in a final step; freeing a writer
// grants it in the next walk step. Output stalls lengthen each step by the stall.
// Synchronous active-low reset empties the queue, clears all holders and sets
// queue_limit to 16; the queue memory itself is not cleared.
`default_nettype none

module fifo_readers_writer_lock_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire  fwl_pkg::t_in_word      i_in_word,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output fwl_pkg::t_out_word           o_out_word,
    input  wire                          i_out_stall,
    input  wire                          i_cfg_we,
    input  wire  [fwl_pkg::LIMIT_W-1:0]  i_cfg_wdata
);
    import fwl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [READERS_W-1:0] r_readers;
    logic [READERS_W-1:0] n_readers;
    logic                 r_writer_act;
    logic                 n_writer_act;
    logic [CNT_W-1:0]     r_pend_w;
    logic [CNT_W-1:0]     n_pend_w;
    logic                 r_pend_valid;
    logic                 n_pend_valid;
    logic [ID_W-1:0]      r_pend_id;
    logic [ID_W-1:0]      n_pend_id;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_out_valid;
    t_out_word            r_out;

    t_q_ctl               q_ctl;
    logic [CNT_W-1:0]     q_count;
    t_entry               q_head;

    logic                 can_load;
    logic                 in_accept;
    logic                 emit;
    t_out_word            res;
    logic [CMP_W-1:0]     lim_ext;
    logic [CMP_W-1:0]     eff_limit;
    logic                 q_full;

    fwl_wait_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (q_ctl),
        .o_count      (q_count),
        .o_head_entry (q_head)
    );

    assign can_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && can_load);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign lim_ext   = CMP_W'(r_limit);
    assign eff_limit = (lim_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : lim_ext;
    assign q_full    = CMP_W'(q_count) >= eff_limit;

    always_comb begin
        n_state      = r_state;
        n_readers    = r_readers;
        n_writer_act = r_writer_act;
        n_pend_w     = r_pend_w;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        q_ctl        = '0;
        emit         = 1'b0;
        res          = '0;
        res.last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    q_ctl.entry.id = i_in_word.requester_id;
                    unique case (i_in_word.command)
                        CMD_ENTER_READ: begin
                            emit = 1'b1;
                            if (r_writer_act || (r_pend_w != '0)) begin
                                if (q_full) begin
                                    res.status = ST_FULL;
                                end else begin
                                    res.status       = ST_QUEUED;
                                    q_ctl.push       = 1'b1;
                                    q_ctl.entry.kind = KIND_READ;
                                end
                            end else if (r_readers == READERS_MAX) begin
                                res.status = ST_FULL;
                            end else begin
                                n_readers       = r_readers + 1'b1;
                                res.status      = ST_GRANTED;
                                res.grant_valid = 1'b1;
                                res.grant_id    = i_in_word.requester_id;
                                res.grant_kind  = KIND_READ;
                            end
                        end
                        CMD_ENTER_WRITE: begin
                            emit = 1'b1;
                            if ((r_readers != '0) || r_writer_act) begin
                                if (q_full) begin
                                    res.status = ST_FULL;
                                end else begin
                                    res.status       = ST_QUEUED;
                                    q_ctl.push       = 1'b1;
                                    q_ctl.entry.kind = KIND_WRITE;
                                    n_pend_w         = r_pend_w + 1'b1;
                                end
                            end else begin
                                n_writer_act    = 1'b1;
                                res.status      = ST_GRANTED;
                                res.grant_valid = 1'b1;
                                res.grant_id    = i_in_word.requester_id;
                                res.grant_kind  = KIND_WRITE;
                            end
                        end
                        CMD_LEAVE_READ: begin
                            if (r_readers == '0) begin
                                emit       = 1'b1;
                                res.status = ST_NO_HOLDER;
                            end else begin
                                n_readers = r_readers - 1'b1;
                                if ((r_readers != READERS_W'(1)) || (q_count == '0)) begin
                                    emit       = 1'b1;
                                    res.status = ST_NONE;
                                end else begin
                                    n_state      = S_WALK;
                                    n_pend_valid = 1'b0;
                                end
                            end
                        end
                        CMD_LEAVE_WRITE: begin
                            if (!r_writer_act) begin
                                emit       = 1'b1;
                                res.status = ST_NO_HOLDER;
                            end else begin
                                n_writer_act = 1'b0;
                                if ((r_readers != '0) || (q_count == '0)) begin
                                    emit       = 1'b1;
                                    res.status = ST_NONE;
                                end else begin
                                    n_state      = S_WALK;
                                    n_pend_valid = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                // A released reader is held back one step so that its last
                // flag can be settled once the following entry is known.
                if (can_load) begin
                    res.status      = ST_GRANTED;
                    res.grant_valid = 1'b1;
                    if ((q_count == '0) || (q_head.kind && (r_readers != '0))) begin
                        emit            = 1'b1;
                        res.grant_id    = r_pend_id;
                        res.grant_kind  = KIND_READ;
                        n_state         = S_IDLE;
                    end else if (q_head.kind) begin
                        q_ctl.pop       = 1'b1;
                        emit            = 1'b1;
                        n_writer_act    = 1'b1;
                        n_pend_w        = (r_pend_w != '0) ? r_pend_w - 1'b1 : r_pend_w;
                        res.grant_id    = q_head.id;
                        res.grant_kind  = KIND_WRITE;
                        n_state         = S_IDLE;
                    end else begin
                        q_ctl.pop       = 1'b1;
                        emit            = r_pend_valid;
                        n_readers       = r_readers + 1'b1;
                        n_pend_valid    = 1'b1;
                        n_pend_id       = q_head.id;
                        res.grant_id    = r_pend_id;
                        res.grant_kind  = KIND_READ;
                        res.last        = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_readers    <= '0;
            r_writer_act <= 1'b0;
            r_pend_w     <= '0;
            r_pend_valid <= 1'b0;
            r_limit      <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_readers    <= n_readers;
            r_writer_act <= n_writer_act;
            r_pend_w     <= n_pend_w;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`include "fifo_readers_writer_lock_top_macros.svh"

    // A writer and readers never hold the lock together.
    `FWL_ASSERT_IMP(a_exclusive, i_clk, i_rst_n, r_writer_act, r_readers == '0)
    // The queue never holds more words than its storage.
    `FWL_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, CMP_W'(q_count) <= CMP_W'(QUEUE_DEPTH))
    // A release walk starts only with no writer holding the lock.
    `FWL_ASSERT_IMP(a_walk_nowr, i_clk, i_rst_n, r_state == S_WALK, !r_writer_act)
    // Accepting a word that starts a walk never loads the output register.
    `FWL_ASSERT_NXT(a_walk_quiet, i_clk, i_rst_n, (r_state == S_IDLE) && (n_state == S_WALK),
                    r_out_valid == $past(r_out_valid && i_out_stall))

endmodule

`default_nettype wire
